@@ sv/apqlc_pkg.sv @@
package apqlc_pkg;

  localparam int QueueDepth  = 256;
  localparam int QIdxW       = $clog2(QueueDepth);
  localparam int QCntW       = QIdxW + 1;
  localparam int CancelDepth = 64;
  localparam int CIdxW       = $clog2(CancelDepth);
  localparam int CCntW       = CIdxW + 1;
  localparam int IdBits      = 16;
  localparam int KeyW        = 48;
  localparam int TimeW       = 24;
  localparam int SevW        = 24;
  localparam int RateW       = 24;
  localparam int OpW         = 2;
  localparam int ProdW       = 2 * (RateW + 1);
  localparam int Horizon     = 10000000;
  localparam int FifoDepth   = 4;
  localparam int FifoIdxW    = $clog2(FifoDepth);
  localparam int FifoCntW    = FifoIdxW + 1;

  localparam logic [OpW-1:0] OpArrive = 2'd0;
  localparam logic [OpW-1:0] OpServe  = 2'd1;
  localparam logic [OpW-1:0] OpCancel = 2'd2;
  localparam logic [OpW-1:0] OpNone   = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [IdBits-1:0] id;
    logic [KeyW-1:0]   key;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [IdBits-1:0] id;
    logic              arr_drop;
    logic              can_drop;
  } result_t;

endpackage

@@ sv/apqlc_ram.sv @@
module apqlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/apqlc_front.sv @@
module apqlc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apqlc_pkg::RateW-1:0]   cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [apqlc_pkg::OpW-1:0]     opcode_i,
  input  logic [apqlc_pkg::TimeW-1:0]   arrival_time_i,
  input  logic [apqlc_pkg::IdBits-1:0]  patient_id_i,
  input  logic [apqlc_pkg::SevW-1:0]    severity_i,
  output apqlc_pkg::cmd_t               cmd_o,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i
);
  import apqlc_pkg::*;

  localparam logic signed [ProdW:0] SumMax =
    {{(ProdW - KeyW + 2){1'b0}}, {(KeyW - 1){1'b1}}};
  localparam logic signed [ProdW:0] SumMin =
    {{(ProdW - KeyW + 2){1'b1}}, {(KeyW - 1){1'b0}}};

  logic [RateW-1:0]        rate_q;
  logic                    s1_v_q;
  logic [OpW-1:0]          s1_op_q;
  logic [IdBits-1:0]       s1_id_q;
  logic [TimeW-1:0]        s1_t_q;
  logic [SevW-1:0]         s1_sev_q;
  logic                    s2_v_q;
  logic [OpW-1:0]          s2_op_q;
  logic [IdBits-1:0]       s2_id_q;
  logic [SevW-1:0]         s2_sev_q;
  logic signed [ProdW-1:0] s2_prod_q;

  logic                    s2_free;
  logic                    s1_move;
  logic                    accept;
  logic signed [TimeW:0]   diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW:0]   sum;
  logic [KeyW-1:0]         key;

  assign cfg_ready_o = 1'b1;
  assign s2_free     = !s2_v_q || cmd_ready_i;
  assign s1_move     = s1_v_q && s2_free;
  assign full_o      = s1_v_q && !s2_free;
  assign accept      = push_i && !full_o;

  assign diff = $signed((TimeW + 1)'(Horizon)) - $signed({1'b0, s1_t_q});
  assign prod = $signed({1'b0, rate_q}) * diff;
  assign sum  = $signed({s2_prod_q[ProdW-1], s2_prod_q})
              + $signed({{(ProdW + 1 - SevW){1'b0}}, s2_sev_q});

  always_comb begin
    if (sum > SumMax) begin
      key = SumMax[KeyW-1:0];
    end else if (sum < SumMin) begin
      key = SumMin[KeyW-1:0];
    end else begin
      key = sum[KeyW-1:0];
    end
  end

  assign cmd_valid_o = s2_v_q;
  assign cmd_o       = '{op: s2_op_q, id: s2_id_q, key: key};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rate_q <= cfg_data_i;
      end
      if (accept) begin
        s1_v_q <= (opcode_i != OpNone);
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (cmd_ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= opcode_i;
      s1_id_q  <= patient_id_i;
      s1_t_q   <= arrival_time_i;
      s1_sev_q <= severity_i;
    end
    if (s1_move) begin
      s2_op_q   <= s1_op_q;
      s2_id_q   <= s1_id_q;
      s2_sev_q  <= s1_sev_q;
      s2_prod_q <= prod;
    end
  end

endmodule

@@ sv/apqlc_fifo.sv @@
module apqlc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  apqlc_pkg::cmd_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output apqlc_pkg::cmd_t rdata_o,
  output logic            empty_o
);
  import apqlc_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoIdxW-1:0] wptr_q;
  logic [FifoIdxW-1:0] rptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/apqlc_back.sv @@
module apqlc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apqlc_pkg::cmd_t    cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  output apqlc_pkg::result_t res_o,
  output logic               res_valid_o,
  input  logic               res_ready_i
);
  import apqlc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StBest = 3'd1;
  localparam logic [2:0] StCan  = 3'd2;
  localparam logic [2:0] StRem0 = 3'd3;
  localparam logic [2:0] StRem1 = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  localparam int EntW = KeyW + IdBits;

  logic [2:0]             state_q, state_d;
  logic [QCntW-1:0]       count_q, count_d;
  logic                   arr_drop_q, arr_drop_d;
  logic                   can_drop_q, can_drop_d;
  logic [CancelDepth-1:0] used_q, used_d;
  logic                   serve_q, serve_d;
  logic [IdBits-1:0]      target_q, target_d;
  logic [QCntW-1:0]       rd_q, rd_d;
  logic                   pend_q, pend_d;
  logic [QIdxW-1:0]       pend_idx_q, pend_idx_d;
  logic                   have_q, have_d;
  logic [KeyW-1:0]        best_key_q, best_key_d;
  logic [IdBits-1:0]      best_id_q, best_id_d;
  logic [QIdxW-1:0]       best_idx_q, best_idx_d;
  logic [CCntW-1:0]       cs_q, cs_d;
  logic                   cpend_q, cpend_d;
  logic [CIdxW-1:0]       cpend_idx_q, cpend_idx_d;
  logic                   hit_q, hit_d;
  logic [CIdxW-1:0]       hit_idx_q, hit_idx_d;
  logic                   free_v_q, free_v_d;
  logic [CIdxW-1:0]       free_idx_q, free_idx_d;
  logic                   found_q, found_d;
  logic [IdBits-1:0]      sid_q, sid_d;
  logic                   out_v_q, out_v_d;
  result_t                out_q, out_d;

  logic                   e_we, e_re;
  logic [QIdxW-1:0]       e_waddr, e_raddr;
  logic [EntW-1:0]        e_wdata, e_rdata;
  logic                   c_we, c_re;
  logic [CIdxW-1:0]       c_waddr, c_raddr;
  logic [IdBits-1:0]      c_wdata, c_rdata;
  logic [KeyW-1:0]        rd_key;
  logic [IdBits-1:0]      rd_id;
  logic [QCntW-1:0]       cnt_m1;

  apqlc_ram #(.Width(EntW), .Depth(QueueDepth)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  apqlc_ram #(.Width(IdBits), .Depth(CancelDepth)) u_cancel_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  assign rd_key      = e_rdata[EntW-1:IdBits];
  assign rd_id       = e_rdata[IdBits-1:0];
  assign cnt_m1      = count_q - 1'b1;
  assign cmd_ready_o = (state_q == StIdle);
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    arr_drop_d  = arr_drop_q;
    can_drop_d  = can_drop_q;
    used_d      = used_q;
    serve_d     = serve_q;
    target_d    = target_q;
    rd_d        = rd_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    have_d      = have_q;
    best_key_d  = best_key_q;
    best_id_d   = best_id_q;
    best_idx_d  = best_idx_q;
    cs_d        = cs_q;
    cpend_d     = cpend_q;
    cpend_idx_d = cpend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_v_d    = free_v_q;
    free_idx_d  = free_idx_q;
    found_d     = found_q;
    sid_d       = sid_q;
    out_v_d     = out_v_q && !res_ready_i;
    out_d       = out_q;
    e_we        = 1'b0;
    e_waddr     = count_q[QIdxW-1:0];
    e_wdata     = {cmd_i.key, cmd_i.id};
    e_re        = 1'b0;
    e_raddr     = rd_q[QIdxW-1:0];
    c_we        = 1'b0;
    c_waddr     = free_idx_q;
    c_wdata     = target_q;
    c_re        = 1'b0;
    c_raddr     = cs_q[CIdxW-1:0];

    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OpArrive: begin
              if (count_q == QCntW'(QueueDepth)) begin
                arr_drop_d = 1'b1;
              end else begin
                e_we    = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OpCancel: begin
              target_d = cmd_i.id;
              serve_d  = 1'b0;
              cs_d     = '0;
              cpend_d  = 1'b0;
              hit_d    = 1'b0;
              free_v_d = 1'b0;
              state_d  = StCan;
            end
            OpServe: begin
              found_d = 1'b0;
              sid_d   = '0;
              if (count_q == '0) begin
                state_d = StEmit;
              end else begin
                rd_d    = '0;
                pend_d  = 1'b0;
                have_d  = 1'b0;
                state_d = StBest;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StBest: begin
        e_re       = (rd_q < count_q);
        pend_d     = e_re;
        pend_idx_d = rd_q[QIdxW-1:0];
        if (e_re) begin
          rd_d = rd_q + 1'b1;
        end
        if (pend_q) begin
          if (!have_q || ($signed(rd_key) > $signed(best_key_q)) ||
              ((rd_key == best_key_q) && (rd_id < best_id_q))) begin
            have_d     = 1'b1;
            best_key_d = rd_key;
            best_id_d  = rd_id;
            best_idx_d = pend_idx_q;
          end
        end
        if (!e_re && !pend_q) begin
          target_d = best_id_q;
          serve_d  = 1'b1;
          cs_d     = '0;
          cpend_d  = 1'b0;
          hit_d    = 1'b0;
          free_v_d = 1'b0;
          state_d  = StCan;
        end
      end
      StCan: begin
        c_re        = (cs_q < CCntW'(CancelDepth)) && !hit_q;
        cpend_d     = c_re;
        cpend_idx_d = cs_q[CIdxW-1:0];
        if (c_re) begin
          cs_d = cs_q + 1'b1;
          if (!free_v_q && !used_q[cs_q[CIdxW-1:0]]) begin
            free_v_d   = 1'b1;
            free_idx_d = cs_q[CIdxW-1:0];
          end
        end
        if (cpend_q && !hit_q && used_q[cpend_idx_q] && (c_rdata == target_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = cpend_idx_q;
        end
        if (!c_re && !cpend_q) begin
          if (!serve_q) begin
            state_d = StIdle;
            if (!hit_q) begin
              if (free_v_q) begin
                c_we               = 1'b1;
                used_d[free_idx_q] = 1'b1;
              end else begin
                can_drop_d = 1'b1;
              end
            end
          end else begin
            state_d = StRem0;
            if (hit_q) begin
              used_d[hit_idx_q] = 1'b0;
            end else begin
              found_d = 1'b1;
              sid_d   = best_id_q;
            end
          end
        end
      end
      StRem0: begin
        count_d = cnt_m1;
        e_re    = 1'b1;
        e_raddr = cnt_m1[QIdxW-1:0];
        state_d = StRem1;
      end
      StRem1: begin
        e_we    = 1'b1;
        e_waddr = best_idx_q;
        e_wdata = e_rdata;
        if (found_q || (count_q == '0)) begin
          state_d = StEmit;
        end else begin
          rd_d    = '0;
          pend_d  = 1'b0;
          have_d  = 1'b0;
          state_d = StBest;
        end
      end
      StEmit: begin
        if (!out_v_q || res_ready_i) begin
          out_v_d = 1'b1;
          out_d   = '{found: found_q, id: sid_q, arr_drop: arr_drop_q,
                      can_drop: can_drop_q};
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      arr_drop_q <= 1'b0;
      can_drop_q <= 1'b0;
      used_q     <= '0;
      out_v_q    <= 1'b0;
      pend_q     <= 1'b0;
      cpend_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      arr_drop_q <= arr_drop_d;
      can_drop_q <= can_drop_d;
      used_q     <= used_d;
      out_v_q    <= out_v_d;
      pend_q     <= pend_d;
      cpend_q    <= cpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    serve_q     <= serve_d;
    target_q    <= target_d;
    rd_q        <= rd_d;
    pend_idx_q  <= pend_idx_d;
    have_q      <= have_d;
    best_key_q  <= best_key_d;
    best_id_q   <= best_id_d;
    best_idx_q  <= best_idx_d;
    cs_q        <= cs_d;
    cpend_idx_q <= cpend_idx_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    free_v_q    <= free_v_d;
    free_idx_q  <= free_idx_d;
    found_q     <= found_d;
    sid_q       <= sid_d;
    out_q       <= out_d;
  end

endmodule

@@ sv/aging_priority_queue_lazy_cancel_top.sv @@
// Aging priority queue with lazy cancellation.
// Requests enter through push/full: arrive (store id with aged key),
// serve (pop the best waiting id) and cancel (mark an id for discard).
// Only serve requests produce a result, read through empty/pop; the
// result register frees the moment pop takes it.
// aging_rate is written on cfg_valid_i (always ready); the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Front end: two registered stages (capture, key multiply), then a four-entry
// command queue, so requests keep flowing while the back end works.
// Back end steps per request, using the entry and cancel RAMs:
//   arrive: written into the entry RAM
//   cancel: dispatch, then linear scan of the cancel set
//   serve : dispatch; per examined top entry a best-key scan, a cancel-set scan
//           and a removal, repeated per cancelled top discarded; post result.
// Reset empties the queue, the cancel set and the drop flags and zeroes
// aging_rate; no clearing pass is needed.
// When the receiver stalls, the finished result holds and the back end waits
// with its next result; the command queue then fills and full rises.
module aging_priority_queue_lazy_cancel_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apqlc_pkg::RateW-1:0]   cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [apqlc_pkg::OpW-1:0]     opcode_i,
  input  logic [apqlc_pkg::TimeW-1:0]   arrival_time_i,
  input  logic [apqlc_pkg::IdBits-1:0]  patient_id_i,
  input  logic [apqlc_pkg::SevW-1:0]    severity_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          found_o,
  output logic [apqlc_pkg::IdBits-1:0]  served_id_o,
  output logic                          arrival_dropped_o,
  output logic                          cancel_dropped_o
);
  import apqlc_pkg::*;

  cmd_t    f_cmd;
  logic    f_valid;
  logic    fq_full;
  cmd_t    fq_cmd;
  logic    fq_empty;
  logic    b_ready;
  result_t res;
  logic    res_valid;

  apqlc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .full_o         (full),
    .opcode_i       (opcode_i),
    .arrival_time_i (arrival_time_i),
    .patient_id_i   (patient_id_i),
    .severity_i     (severity_i),
    .cmd_o          (f_cmd),
    .cmd_valid_o    (f_valid),
    .cmd_ready_i    (!fq_full)
  );

  apqlc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .wdata_i (f_cmd),
    .full_o  (fq_full),
    .pop_i   (b_ready),
    .rdata_o (fq_cmd),
    .empty_o (fq_empty)
  );

  apqlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fq_cmd),
    .cmd_valid_i (!fq_empty),
    .cmd_ready_o (b_ready),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (pop)
  );

  assign empty             = !res_valid;
  assign found_o           = res.found;
  assign served_id_o       = res.id;
  assign arrival_dropped_o = res.arr_drop;
  assign cancel_dropped_o  = res.can_drop;

  a_no_id_without_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (served_id_o == '0))
    else $error("served id set on an empty serve");

  a_arr_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && arrival_dropped_o) |=> (empty || arrival_dropped_o))
    else $error("arrival drop flag cleared");

  a_can_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && cancel_dropped_o) |=> (empty || cancel_dropped_o))
    else $error("cancel drop flag cleared");

  a_front_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && fq_full) |=> $stable(f_cmd))
    else $error("front request lost while command queue full");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import apqlc_pkg::*;

  localparam longint KeyMax = 64'sd140737488355327;
  localparam longint KeyMin = -KeyMax - 1;
  localparam int LatencyWait = 600;
  localparam int HoldCycles = 3000;

  typedef struct {
    logic [OpW-1:0]    op;
    logic [TimeW-1:0]  t;
    logic [IdBits-1:0] id;
    logic [SevW-1:0]   sev;
  } request_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [RateW-1:0] cfg_data_i;
  logic push, full, empty, pop;
  logic [OpW-1:0] opcode_i;
  logic [TimeW-1:0] arrival_time_i;
  logic [IdBits-1:0] patient_id_i;
  logic [SevW-1:0] severity_i;
  logic found_o, arrival_dropped_o, cancel_dropped_o;
  logic [IdBits-1:0] served_id_o;

  aging_priority_queue_lazy_cancel_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .push(push), .full(full), .opcode_i(opcode_i),
    .arrival_time_i(arrival_time_i), .patient_id_i(patient_id_i),
    .severity_i(severity_i), .empty(empty), .pop(pop),
    .found_o(found_o), .served_id_o(served_id_o),
    .arrival_dropped_o(arrival_dropped_o), .cancel_dropped_o(cancel_dropped_o)
  );

  request_t pending_reqs[$];
  result_t served_expect[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase_no = 0;

  // scheduler mirror
  longint wait_key[QueueDepth];
  logic [IdBits-1:0] wait_id[QueueDepth];
  int wait_cnt = 0;
  logic [IdBits-1:0] cancel_id[CancelDepth];
  bit cancel_live[CancelDepth];
  bit arr_drop_flag = 0;
  bit can_drop_flag = 0;
  logic [RateW-1:0] rate_q = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint aged_key(logic [TimeW-1:0] t, logic [SevW-1:0] s);
    longint k;
    k = longint'(s) + longint'(rate_q) * (longint'(Horizon) - longint'(t));
    if (k > KeyMax) k = KeyMax;
    if (k < KeyMin) k = KeyMin;
    return k;
  endfunction

  function automatic int find_cancel(logic [IdBits-1:0] id);
    for (int i = 0; i < CancelDepth; i++)
      if (cancel_live[i] && cancel_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void take_slot(int i);
    wait_cnt--;
    wait_key[i] = wait_key[wait_cnt];
    wait_id[i] = wait_id[wait_cnt];
  endfunction

  function automatic void apply_request(request_t r);
    result_t res;
    int b, c;
    bit placed;
    case (r.op)
      OpArrive: begin
        if (wait_cnt >= QueueDepth) begin
          arr_drop_flag = 1'b1;
        end else begin
          wait_key[wait_cnt] = aged_key(r.t, r.sev);
          wait_id[wait_cnt] = r.id;
          wait_cnt++;
        end
      end
      OpCancel: begin
        if (find_cancel(r.id) < 0) begin
          placed = 1'b0;
          for (int i = 0; i < CancelDepth && !placed; i++)
            if (!cancel_live[i]) begin
              cancel_live[i] = 1'b1;
              cancel_id[i] = r.id;
              placed = 1'b1;
            end
          if (!placed) can_drop_flag = 1'b1;
        end
      end
      OpServe: begin
        res.found = 1'b0;
        res.id = '0;
        while (wait_cnt > 0 && !res.found) begin
          b = 0;
          for (int i = 1; i < wait_cnt; i++)
            if (wait_key[i] > wait_key[b] ||
                (wait_key[i] == wait_key[b] && wait_id[i] < wait_id[b])) b = i;
          c = find_cancel(wait_id[b]);
          if (c >= 0) begin
            cancel_live[c] = 1'b0;
          end else begin
            res.found = 1'b1;
            res.id = wait_id[b];
          end
          take_slot(b);
        end
        res.arr_drop = arr_drop_flag;
        res.can_drop = can_drop_flag;
        served_expect.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      opcode_i <= OpNone;
      arrival_time_i <= '0;
      patient_id_i <= '0;
      severity_i <= '0;
    end else if (push && full) begin
      push <= 1'b1;
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      push <= 1'b1;
      opcode_i <= pending_reqs[0].op;
      arrival_time_i <= pending_reqs[0].t;
      patient_id_i <= pending_reqs[0].id;
      severity_i <= pending_reqs[0].sev;
    end else begin
      push <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      apply_request(pending_reqs.pop_front());
    end
  end

  // result receiver
  int hold_cnt = 0;
  bit held = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (phase_no == 2 && !held) begin
      held <= 1'b1;
      hold_cnt <= HoldCycles;
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (served_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b id=%0h", found_o, served_id_o);
      end else begin
        want = served_expect.pop_front();
        if (found_o !== want.found || served_id_o !== want.id ||
            arrival_dropped_o !== want.arr_drop || cancel_dropped_o !== want.can_drop) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp found=%0b id=%0h ad=%0b cd=%0b,",
                      " got found=%0b id=%0h ad=%0b cd=%0b"},
                     want.found, want.id, want.arr_drop, want.can_drop,
                     found_o, served_id_o, arrival_dropped_o, cancel_dropped_o);
        end
      end
    end
  end

  task automatic add_req(logic [OpW-1:0] op, logic [TimeW-1:0] t,
                         logic [IdBits-1:0] id, logic [SevW-1:0] sev);
    request_t r;
    r.op = op;
    r.t = t;
    r.id = id;
    r.sev = sev;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    int r;
    logic [OpW-1:0] op;
    logic [TimeW-1:0] t;
    logic [IdBits-1:0] id;
    logic [SevW-1:0] sev;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = (r < 40) ? OpArrive : (r < 75) ? OpServe : (r < 95) ? OpCancel : OpNone;
      id = ($urandom_range(9) == 0) ? IdBits'($urandom) : IdBits'($urandom_range(31));
      r = $urandom_range(3);
      t = (r == 0) ? TimeW'($urandom) :
          (r == 1) ? TimeW'(Horizon - $urandom_range(50)) : TimeW'($urandom_range(Horizon));
      sev = $urandom_range(1) ? SevW'($urandom) : SevW'($urandom_range(20));
      add_req(op, t, id, sev);
    end
  endtask

  task automatic drain_and_settle();
    while (pending_reqs.size() > 0 || served_expect.size() > 0) @(negedge clk_i);
    repeat (LatencyWait) @(negedge clk_i);
  endtask

  task automatic write_rate(logic [RateW-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    rate_q = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_rate('1);
    add_req(OpServe, '0, '0, '0);
    add_req(OpArrive, '0, '0, '0);
    add_req(OpArrive, '1, '1, '1);
    add_req(OpArrive, TimeW'(Horizon), 16'd5, 24'd5);
    add_req(OpArrive, TimeW'(Horizon), 16'd7, 24'd100);
    add_req(OpArrive, TimeW'(Horizon), 16'd7, 24'd100);
    add_req(OpArrive, TimeW'(Horizon), 16'd9, 24'd100);
    add_req(OpArrive, TimeW'(Horizon), 16'd8, 24'd100);
    add_req(OpCancel, '1, 16'd7, '1);
    add_req(OpCancel, '0, 16'd7, '0);
    add_req(OpNone, '1, '1, '1);
    add_req(OpCancel, '0, 16'd5, '0);
    repeat (8) add_req(OpServe, '0, '0, '0);
    drain_and_settle();

    write_rate(24'd1);
    sender_idle_pct = 6;
    recv_idle_pct = 52;
    add_random(200);
    for (int i = 0; i < 270; i++)
      add_req(OpArrive, TimeW'($urandom), IdBits'($urandom_range(63)), SevW'($urandom));
    repeat (275) add_req(OpServe, '0, '0, '0);
    add_random(200);
    drain_and_settle();

    write_rate('0);
    sender_idle_pct = 52;
    recv_idle_pct = 6;
    add_random(150);
    for (int i = 0; i < 70; i++) add_req(OpCancel, '0, IdBits'(16'hF000 + i), '0);
    for (int i = 0; i < 70; i++)
      add_req(OpArrive, TimeW'($urandom), IdBits'(16'hF000 + i), SevW'($urandom));
    repeat (72) add_req(OpServe, '0, '0, '0);
    add_random(150);
    drain_and_settle();

    write_rate(RateW'($urandom));
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    phase_no = 2;
    add_random(200);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
